>>> rtl/pmac_pkg.sv
// Shared constants, types and saturation helpers for the pointwise MAC tile.
`default_nettype none
package pmac_pkg;

  localparam int TILE_PIXELS  = 256;
  localparam int OUT_CHANNELS = 16;
  localparam int IN_GROUP     = 4;
  localparam int DATA_WIDTH   = 16;
  localparam int ACC_WIDTH    = 32;

  // fixed field widths of the stream beats
  localparam int PIX_W   = 8;
  localparam int OC_W    = 4;
  localparam int IC_W    = 2;
  localparam int SHIFT_W = 4;

  localparam int PIX_AW = (TILE_PIXELS > 1) ? $clog2(TILE_PIXELS) : 1;
  localparam int IGW    = (IN_GROUP > 1) ? $clog2(IN_GROUP) : 1;
  localparam int CHW    = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int DOT_W  = PROD_W + IGW;
  localparam int SUM_W  = ((DOT_W > ACC_WIDTH) ? DOT_W : ACC_WIDTH) + 1;

  localparam logic OP_WEIGHT = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [ACC_WIDTH-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  // per-cycle control shared by all lanes
  typedef struct packed {
    logic              adv;      // pipeline moves this cycle
    logic [PIX_AW-1:0] rd_addr;  // accumulator read for the incoming beat
    logic              wr_en;    // last stage writes back
    logic [PIX_AW-1:0] wr_addr;
    logic              clear;    // last stage starts from zero
    logic [2:0]        fwd;      // bypass from write history, newest first
  } lane_ctl_t;

  function automatic acc_t sat_acc(input sum_t v);
    logic [SUM_W-ACC_WIDTH:0] top;
    top = v[SUM_W-1:ACC_WIDTH-1];
    if (&top || ~|top) return v[ACC_WIDTH-1:0];
    return v[SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
  endfunction

  function automatic data_t sat_data(input acc_t v);
    logic [ACC_WIDTH-DATA_WIDTH:0] top;
    top = v[ACC_WIDTH-1:DATA_WIDTH-1];
    if (&top || ~|top) return v[DATA_WIDTH-1:0];
    return v[ACC_WIDTH-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
  endfunction

endpackage
`default_nettype wire

>>> rtl/pmac_ram.sv
// Generic simple dual-port RAM, read-first, registered read.
`default_nettype none
module pmac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire                             clk,
  input  wire                             we,
  input  wire  [$clog2(DEPTH)-1:0]        waddr,
  input  wire  [WIDTH-1:0]                wdata,
  input  wire                             re,
  input  wire  [$clog2(DEPTH)-1:0]        raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/pmac_lane.sv
// One output-channel lane: weight row, four multipliers, dot sum, accumulator RAM.
`default_nettype none
module pmac_lane (
  input  wire                           clk,
  input  pmac_pkg::lane_ctl_t           ctl,
  input  wire                           wt_we,
  input  wire  [pmac_pkg::IGW-1:0]      wt_ic,
  input  pmac_pkg::data_t               wt_value,
  input  wire  [pmac_pkg::SHIFT_W-1:0]  product_shift,
  input  pmac_pkg::data_t               x [pmac_pkg::IN_GROUP],
  output pmac_pkg::data_t               sum_out
);
  import pmac_pkg::*;

  data_t w [IN_GROUP];
  prod_t prod [IN_GROUP];
  acc_t  acc_rd, acc_rd2;
  dot_t  dot, dot_next;
  acc_t  h1, h2, h3;
  acc_t  base, acc_new;
  logic [ACC_WIDTH-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (wt_we) begin
      w[wt_ic] <= wt_value;
    end
  end

  pmac_ram #(.WIDTH(ACC_WIDTH), .DEPTH(TILE_PIXELS)) u_acc_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (ctl.wr_addr),
    .wdata (acc_new),
    .re    (ctl.adv),
    .raddr (ctl.rd_addr),
    .rdata (ram_rdata)
  );

  // floor shift of each product, then the lane's dot sum
  always_comb begin
    dot_next = '0;
    for (int i = 0; i < IN_GROUP; i++) begin
      dot_next = dot_next + DOT_W'(prod[i] >>> product_shift);
    end
  end

  always_comb begin
    if (ctl.clear)       base = '0;
    else if (ctl.fwd[0]) base = h1;
    else if (ctl.fwd[1]) base = h2;
    else if (ctl.fwd[2]) base = h3;
    else                 base = acc_rd2;
    acc_new = sat_acc(SUM_W'(base) + SUM_W'(dot));
  end

  assign sum_out = sat_data(acc_new);

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int i = 0; i < IN_GROUP; i++) begin
        prod[i] <= x[i] * w[i];
      end
      acc_rd  <= ram_rdata;
      dot     <= dot_next;
      acc_rd2 <= acc_rd;
      // writes the RAM read of a younger beat has not seen yet
      h1      <= acc_new;
      h2      <= h1;
      h3      <= h2;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pmac_merge.sv
// Output serializer: takes all lane sums of a pixel and sends them one beat per channel.
`default_nettype none
module pmac_merge (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          load,
  input  wire  [pmac_pkg::PIX_W-1:0]   load_pixel,
  input  pmac_pkg::data_t              sums [pmac_pkg::OUT_CHANNELS],
  output logic                         load_ready,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [31:0]                  m_tdata,   // out_pixel, out_channel, sum_value, pad
  output logic                         m_tlast
);
  import pmac_pkg::*;

  localparam logic [CHW-1:0] CH_LAST = CHW'(OUT_CHANNELS - 1);

  data_t             buf_sum [OUT_CHANNELS];
  logic [PIX_W-1:0]  buf_pixel;
  logic [CHW-1:0]    cnt;
  logic              busy;
  logic              at_last;

  assign at_last    = (cnt == CH_LAST);
  assign load_ready = !busy || (at_last && m_tready);
  assign m_tvalid   = busy;
  assign m_tlast    = at_last;
  assign m_tdata    = {4'd0, buf_sum[cnt], OC_W'(cnt), buf_pixel};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && m_tready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_pixel <= load_pixel;
      for (int c = 0; c < OUT_CHANNELS; c++) begin
        buf_sum[c] <= sums[c];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/pointwise_conv_mac_tile.sv
// Top level of the pointwise convolution MAC tile: input stage, lanes, serializer.
//
//  channel  | direction | carries
//  s_*      | in        | weight word or pixel beat (tuser: op, first_group; tlast: last_group)
//  m_*      | out       | one saturated sum per beat (tlast on the final channel)
//  cfg_*    | in        | product_shift write
//
// One beat is taken per cycle unless the input is stalled. A pixel beat passes three pipeline
// stages (multiply, dot sum, accumulate and write back); with last_group its sums are loaded
// into the serializer and sent on m_*, one channel per beat, until the final channel is taken;
// the input stalls only while a finished sum set waits for the busy serializer.
// Read-after-write between close beats of one pixel is bypassed from a write history.
// Synchronous reset clears control only; weights and accumulators are undefined until written.
`default_nettype none
module pointwise_conv_mac_tile (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // weight_out_channel, weight_in_channel, weight_value, pixel, chan_in0..chan_in3, pad
  input  wire  [95:0] s_tdata,
  input  wire  [1:0]  s_tuser,   // op, first_group
  input  wire         s_tlast,   // last_group
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // out_pixel, out_channel, sum_value, pad
  output logic        m_tlast,   // last
  input  wire         cfg_we,
  input  wire  [3:0]  cfg_wdata  // product_shift
);
  import pmac_pkg::*;

  localparam int WOC_LO = 0;
  localparam int WIC_LO = WOC_LO + OC_W;
  localparam int WV_LO  = WIC_LO + IC_W;
  localparam int PIX_LO = WV_LO + DATA_WIDTH;
  localparam int CH_LO  = PIX_LO + PIX_W;

  logic [SHIFT_W-1:0] product_shift;

  logic              take;
  logic              in_op, in_first;
  logic [OC_W-1:0]   in_woc;
  logic [IC_W-1:0]   in_wic;
  data_t             in_wval;
  logic [PIX_W-1:0]  in_pixel;
  logic              in_pix_ok;
  logic              wt_ok;

  logic              adv, merge_ready, merge_load;
  lane_ctl_t         ctl;

  logic              s1_valid, s2_valid, s3_valid;
  logic              s1_first, s2_first, s3_first;
  logic              s1_last, s2_last, s3_last;
  logic [PIX_W-1:0]  s1_pixel, s2_pixel, s3_pixel;
  data_t             s1_x [IN_GROUP];

  logic              hv1, hv2, hv3;
  logic [PIX_W-1:0]  hp1, hp2, hp3;

  data_t             lane_sum [OUT_CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      product_shift <= SHIFT_W'(8);
    end else if (cfg_we) begin
      product_shift <= cfg_wdata;
    end
  end

  assign in_op     = s_tuser[0];
  assign in_first  = s_tuser[1];
  assign in_woc    = s_tdata[WOC_LO +: OC_W];
  assign in_wic    = s_tdata[WIC_LO +: IC_W];
  assign in_wval   = s_tdata[WV_LO +: DATA_WIDTH];
  assign in_pixel  = s_tdata[PIX_LO +: PIX_W];
  assign in_pix_ok = (32'(in_pixel) < TILE_PIXELS);
  assign wt_ok     = (32'(in_woc) < OUT_CHANNELS) && (32'(in_wic) < IN_GROUP);

  // stall only when a sum set is ready but the serializer cannot take it
  assign adv        = !(s3_valid && s3_last && !merge_ready);
  assign s_tready   = adv;
  assign take       = s_tvalid && s_tready;
  assign merge_load = adv && s3_valid && s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      hv1      <= 1'b0;
      hv2      <= 1'b0;
      hv3      <= 1'b0;
    end else if (adv) begin
      s1_valid <= take && (in_op == OP_PIXEL) && in_pix_ok;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      hv1      <= s3_valid;
      hv2      <= hv1;
      hv3      <= hv2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first <= in_first;
      s1_last  <= s_tlast;
      s1_pixel <= in_pixel;
      for (int i = 0; i < IN_GROUP; i++) begin
        s1_x[i] <= (i < 4) ? s_tdata[CH_LO + i * DATA_WIDTH +: DATA_WIDTH] : '0;
      end
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s2_pixel <= s1_pixel;
      s3_first <= s2_first;
      s3_last  <= s2_last;
      s3_pixel <= s2_pixel;
      hp1      <= s3_pixel;
      hp2      <= hp1;
      hp3      <= hp2;
    end
  end

  always_comb begin
    logic m1, m2, m3;
    m1          = hv1 && (hp1 == s3_pixel);
    m2          = hv2 && (hp2 == s3_pixel);
    m3          = hv3 && (hp3 == s3_pixel);
    ctl.adv     = adv;
    ctl.rd_addr = PIX_AW'(in_pixel);
    ctl.wr_en   = adv && s3_valid;
    ctl.wr_addr = PIX_AW'(s3_pixel);
    ctl.clear   = s3_first;
    ctl.fwd     = {m3 && !m2 && !m1, m2 && !m1, m1};
  end

  for (genvar c = 0; c < OUT_CHANNELS; c++) begin : g_lane
    pmac_lane u_lane (
      .clk           (clk),
      .ctl           (ctl),
      .wt_we         (take && (in_op == OP_WEIGHT) && wt_ok && (32'(in_woc) == c)),
      .wt_ic         (IGW'(in_wic)),
      .wt_value      (in_wval),
      .product_shift (product_shift),
      .x             (s1_x),
      .sum_out       (lane_sum[c])
    );
  end

  pmac_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (merge_load),
    .load_pixel (s3_pixel),
    .sums       (lane_sum),
    .load_ready (merge_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (adv && s3_valid && s3_last) |-> merge_ready)
    else $error("sum set advanced into a busy serializer");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    merge_load |=> m_tvalid)
    else $error("loaded sum set not presented");

  a_fwd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctl.fwd))
    else $error("more than one bypass source selected");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(s3_valid) && $stable(s3_pixel)))
    else $error("last stage changed during a stall");

endmodule
`default_nettype wire
